// ===== hw/rtl/gte_pkg.sv =====
// ----------------------------------------------------------------------------
// gte_pkg: shared types and constants for the tilt estimator
// Field widths, gate thresholds, state codes, register indexes and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package gte_pkg;

  // Field widths of one item.
  localparam int ACC_W    = 19;
  localparam int RATE_W   = 21;
  localparam int STAMP_W  = 48;
  localparam int PITCH_W  = 16;
  localparam int ROLL_W   = 17;
  localparam int USED_W   = 7;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int WIN_W      = 7;
  localparam int AGE_W      = 32;
  localparam int ROW_W      = 48;

  // Default sizes.
  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int CORDIC_STEPS_DEF = 16;

  // Internal arithmetic widths.
  localparam int MEAN_W = 28;
  localparam int GRAV_W = 32;
  localparam int CRD_W  = 36;
  localparam int ANG_W  = 28;
  localparam int ATAN_W = 24;

  // Gate and norm thresholds on squared values.
  localparam logic signed [63:0] ACC_NORM2_LO   = 64'sd63959047;
  localparam logic signed [63:0] ACC_NORM2_HI   = 64'sd146251290;
  localparam logic signed [63:0] RATE_NORM2_MAX = 64'sd2044252;
  localparam logic signed [63:0] GRAV_NORM2_MIN = 64'sd68719;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q24 = 28'sd26353589;

  // Register reset values.
  localparam logic [WIN_W-1:0] WIN_RST   = 7'd64;
  localparam logic [WIN_W-1:0] REQ_RST   = 7'd10;
  localparam logic [ROW_W-1:0] ROW_X_RST = 48'h0000_0000_4000;
  localparam logic [ROW_W-1:0] ROW_Y_RST = 48'h0000_4000_0000;
  localparam logic [ROW_W-1:0] ROW_Z_RST = 48'h4000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW   = 3'd0,
    CFG_REQUIRED = 3'd1,
    CFG_MAX_AGE  = 3'd2,
    CFG_ROT_X    = 3'd3,
    CFG_ROT_Y    = 3'd4,
    CFG_ROT_Z    = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GATE, ST_STORE, ST_WALK, ST_DECIDE, ST_DLOAD, ST_DIV, ST_ROT,
    ST_GRND, ST_NORM, ST_NCHK, ST_SQRT, ST_CPRE, ST_CORD, ST_CFIN, ST_DONE
  } state_t;

  // Arctangent of 2^-i in units of 2^-24 rad.
  function automatic logic [ATAN_W-1:0] atan_q24(input logic [4:0] i);
    logic [ATAN_W-1:0] v;
    unique case (i)
      5'd0:  v = 24'd13176795;
      5'd1:  v = 24'd7778716;
      5'd2:  v = 24'd4110060;
      5'd3:  v = 24'd2086331;
      5'd4:  v = 24'd1047214;
      5'd5:  v = 24'd524117;
      5'd6:  v = 24'd262123;
      5'd7:  v = 24'd131069;
      5'd8:  v = 24'd65536;
      5'd9:  v = 24'd32768;
      5'd10: v = 24'd16384;
      5'd11: v = 24'd8192;
      5'd12: v = 24'd4096;
      5'd13: v = 24'd2048;
      5'd14: v = 24'd1024;
      5'd15: v = 24'd512;
      5'd16: v = 24'd256;
      5'd17: v = 24'd128;
      5'd18: v = 24'd64;
      5'd19: v = 24'd32;
      5'd20: v = 24'd16;
      5'd21: v = 24'd8;
      5'd22: v = 24'd4;
      5'd23: v = 24'd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/gte_in_if.sv =====
// ----------------------------------------------------------------------------
// gte_in_if: input sample channel
// Valid/ready channel carrying one IMU sample per item.
// ----------------------------------------------------------------------------
interface gte_in_if
  import gte_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [ACC_W-1:0]   acc_x;
  logic signed [ACC_W-1:0]   acc_y;
  logic signed [ACC_W-1:0]   acc_z;
  logic                      gyro_present;
  logic signed [RATE_W-1:0]  rate_x;
  logic signed [RATE_W-1:0]  rate_y;
  logic signed [RATE_W-1:0]  rate_z;
  logic [STAMP_W-1:0]        stamp_us;

  modport source (output valid, acc_x, acc_y, acc_z, gyro_present, rate_x, rate_y,
                  rate_z, stamp_us, input ready);
  modport sink (input valid, acc_x, acc_y, acc_z, gyro_present, rate_x, rate_y,
                rate_z, stamp_us, output ready);
endinterface

// ===== hw/rtl/gte_out_if.sv =====
// ----------------------------------------------------------------------------
// gte_out_if: result channel
// Valid/ready channel carrying one tilt estimate per item.
// ----------------------------------------------------------------------------
interface gte_out_if
  import gte_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      sample_accepted;
  logic                      estimate_valid;
  logic signed [PITCH_W-1:0] pitch;
  logic signed [ROLL_W-1:0]  roll;
  logic [USED_W-1:0]         samples_used;

  modport source (output valid, sample_accepted, estimate_valid, pitch, roll,
                  samples_used, input ready);
  modport sink (input valid, sample_accepted, estimate_valid, pitch, roll,
                samples_used, output ready);
endinterface

// ===== hw/rtl/gte_ram.sv =====
// ----------------------------------------------------------------------------
// gte_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/gated_accel_tilt_estimator.sv =====
// ----------------------------------------------------------------------------
// gated_accel_tilt_estimator: quasi-static gated pitch and roll estimator
// Gates IMU samples, keeps a ring of accepted accelerations and returns
// pitch and roll of the rotated mean gravity vector, when valid, per sample.
// ----------------------------------------------------------------------------
// Each input item produces exactly one result item. The block handles one
// item at a time, and its pace is set by the single shared 32x32 multiplier,
// the ring walk through the one read port of the sample RAM, the bit-serial
// mean divider, the bit-pair square root and the shared CORDIC stage. A
// finished result may wait in the output register while the next item is
// taken. Configuration registers are to be written only while the block is
// idle; the user is bound to this and the block itself does not enforce it.
module gated_accel_tilt_estimator
  import gte_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gte_in_if.sink                in_chan,
  gte_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PTR_W  = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = ACC_W + PTR_W + 1;
  localparam int NUM_W  = SUM_W + 9;
  localparam int DCNT_W = $clog2(NUM_W);
  localparam int RAM_W  = 3 * ACC_W + STAMP_W;
  localparam int STEPS  = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(WINDOW_DEPTH - 1);

  // Rounded arithmetic right shift, half away from zero.
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
                                                input logic [5:0] k);
    logic [63:0] mag;
    logic [63:0] rm;
    mag = v[63] ? 64'(-v) : 64'(v);
    rm  = (mag + (64'd1 << (k - 6'd1))) >> k;
    return v[63] ? -$signed(rm) : $signed(rm);
  endfunction

  // Control state.
  state_t              state_r, state_nxt;
  logic [PTR_W-1:0]    wp_r, wp_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WIN_W-1:0]    win_cfg_r;
  logic [WIN_W-1:0]    req_cfg_r;
  logic [AGE_W-1:0]    age_cfg_r;
  logic [ROW_W-1:0]    rot_r [3];

  // Captured sample.
  logic signed [ACC_W-1:0]  a_r [3], a_nxt [3];
  logic signed [RATE_W-1:0] w_r [3], w_nxt [3];
  logic                     gp_r, gp_nxt;
  logic [STAMP_W-1:0]       stamp_r, stamp_nxt;

  // Shared multiplier and accumulators.
  logic signed [31:0]  mul_a, mul_b;
  logic signed [63:0]  prod_r;
  logic signed [63:0]  acc_r [3], acc_nxt [3];
  logic [1:0]          row_r, row_nxt, col_r, col_nxt;
  logic                ph_r, ph_nxt;

  // Ring walk.
  logic                accepted_r, accepted_nxt;
  logic [PTR_W-1:0]    rd_addr_r, rd_addr_nxt;
  logic [CNT_W-1:0]    left_r, left_nxt;
  logic                first_r, first_nxt;
  logic                pvld_r, pvld_nxt;
  logic                pfirst_r, pfirst_nxt;
  logic [STAMP_W-1:0]  nstamp_r, nstamp_nxt;
  logic signed [SUM_W-1:0] sum_r [3], sum_nxt [3];
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  // Mean divider.
  logic [1:0]          ax_r, ax_nxt;
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic [CNT_W:0]      rem_r, rem_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic                neg_r, neg_nxt;
  logic signed [MEAN_W-1:0] m_r [3], m_nxt [3];
  logic signed [GRAV_W-1:0] g_r [3], g_nxt [3];

  // Square root.
  logic [63:0]         sq_v_r, sq_v_nxt;
  logic [63:0]         sq_res_r, sq_res_nxt;
  logic [4:0]          si_r, si_nxt;

  // CORDIC.
  logic                which_r, which_nxt;
  logic signed [CRD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [ANG_W-1:0] cz_r, cz_nxt;
  logic [4:0]          ci_r, ci_nxt;
  logic signed [PITCH_W-1:0] pitch_r, pitch_nxt;
  logic signed [ROLL_W-1:0]  roll_r, roll_nxt;
  logic                est_ok_r, est_ok_nxt;

  // Output register payload.
  logic                o_acc_r, o_acc_nxt, o_est_r, o_est_nxt;
  logic signed [PITCH_W-1:0] o_pitch_r, o_pitch_nxt;
  logic signed [ROLL_W-1:0]  o_roll_r, o_roll_nxt;
  logic [USED_W-1:0]   o_used_r, o_used_nxt;

  // RAM port signals.
  logic                ram_we, ram_re;
  logic [RAM_W-1:0]    ram_wdata, ram_rdata;
  logic [STAMP_W-1:0]  rd_stamp;
  logic signed [ACC_W-1:0] rd_acc [3];

  // Combinational temporaries.
  logic                mac_last, gate_ok, walk_keep, div_ge, dec_ok;
  logic [31:0]         win32, fill32;
  logic [PTR_W-1:0]    wp_eff, newest;
  logic [CNT_W-1:0]    fill_eff;
  logic [STAMP_W-1:0]  ns_use;
  logic signed [STAMP_W+1:0] age;
  logic [SUM_W-1:0]    smag;
  logic [CNT_W:0]      dt;
  logic [MEAN_W-1:0]   mq;
  logic [63:0]         sq_bit, sq_try;
  logic signed [CRD_W-1:0] x0, y0, dx, dy;
  logic signed [63:0]  rz;

  // Sample ring: three accelerations over the timestamp.
  gte_ram #(.WIDTH(RAM_W), .DEPTH(WINDOW_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  assign ram_wdata = {a_r[2], a_r[1], a_r[0], stamp_r};
  assign rd_stamp  = ram_rdata[STAMP_W-1:0];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rd_acc[k] = $signed(ram_rdata[STAMP_W + ACC_W*k +: ACC_W]);
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_GATE: begin
        mul_a = (row_r == 2'd0) ? 32'(a_r[col_r]) : 32'(w_r[col_r]);
        mul_b = mul_a;
      end
      ST_ROT: begin
        mul_a = 32'($signed(rot_r[row_r][16*col_r +: 16]));
        mul_b = 32'(m_r[col_r]);
      end
      ST_NORM: begin
        mul_a = 32'(g_r[col_r]);
        mul_b = mul_a;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt    = state_r;
    wp_nxt       = wp_r;
    fill_nxt     = fill_r;
    out_valid_nxt = out_valid_r;
    a_nxt        = a_r;
    w_nxt        = w_r;
    gp_nxt       = gp_r;
    stamp_nxt    = stamp_r;
    acc_nxt      = acc_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    ph_nxt       = ph_r;
    accepted_nxt = accepted_r;
    rd_addr_nxt  = rd_addr_r;
    left_nxt     = left_r;
    first_nxt    = first_r;
    pvld_nxt     = 1'b0;
    pfirst_nxt   = pfirst_r;
    nstamp_nxt   = nstamp_r;
    sum_nxt      = sum_r;
    cnt_nxt      = cnt_r;
    ax_nxt       = ax_r;
    num_nxt      = num_r;
    rem_nxt      = rem_r;
    dcnt_nxt     = dcnt_r;
    neg_nxt      = neg_r;
    m_nxt        = m_r;
    g_nxt        = g_r;
    sq_v_nxt     = sq_v_r;
    sq_res_nxt   = sq_res_r;
    si_nxt       = si_r;
    which_nxt    = which_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    cz_nxt       = cz_r;
    ci_nxt       = ci_r;
    pitch_nxt    = pitch_r;
    roll_nxt     = roll_r;
    est_ok_nxt   = est_ok_r;
    o_acc_nxt    = o_acc_r;
    o_est_nxt    = o_est_r;
    o_pitch_nxt  = o_pitch_r;
    o_roll_nxt   = o_roll_r;
    o_used_nxt   = o_used_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    mac_last     = 1'b0;
    gate_ok      = 1'b0;
    walk_keep    = 1'b0;
    div_ge       = 1'b0;
    dec_ok       = 1'b0;
    win32        = '0;
    fill32       = 32'(fill_r);
    wp_eff       = wp_r;
    newest       = '0;
    fill_eff     = fill_r;
    ns_use       = nstamp_r;
    age          = '0;
    smag         = '0;
    dt           = '0;
    mq           = '0;
    sq_bit       = '0;
    sq_try       = '0;
    x0           = '0;
    y0           = '0;
    dx           = '0;
    dy           = '0;
    rz           = '0;

    in_chan.ready = (state_r == ST_IDLE);

    // The output register empties when the sink takes the item.
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    // Multiply-accumulate stepping shared by the gate, rotation and norm.
    if ((state_r == ST_GATE) || (state_r == ST_ROT) || (state_r == ST_NORM)) begin
      ph_nxt = ~ph_r;
      if (ph_r) begin
        if (state_r == ST_NORM) begin
          acc_nxt[0] = acc_r[0] + prod_r;
          if (col_r != 2'd0) begin
            acc_nxt[1] = acc_r[1] + prod_r;
          end
        end else begin
          acc_nxt[row_r] = acc_r[row_r] + prod_r;
        end
        if (col_r == 2'd2) begin
          col_nxt = 2'd0;
          row_nxt = row_r + 2'd1;
        end else begin
          col_nxt = col_r + 2'd1;
        end
        unique case (state_r)
          ST_GATE: mac_last = (row_r == 2'd1) && (col_r == 2'd2);
          ST_ROT:  mac_last = (row_r == 2'd2) && (col_r == 2'd2);
          default: mac_last = (col_r == 2'd2);
        endcase
      end
    end

    unique case (state_r)
      // Take a sample and start the gate norms.
      ST_IDLE: begin
        if (in_chan.valid) begin
          a_nxt[0]  = in_chan.acc_x;
          a_nxt[1]  = in_chan.acc_y;
          a_nxt[2]  = in_chan.acc_z;
          w_nxt[0]  = in_chan.rate_x;
          w_nxt[1]  = in_chan.rate_y;
          w_nxt[2]  = in_chan.rate_z;
          gp_nxt    = in_chan.gyro_present;
          stamp_nxt = in_chan.stamp_us;
          for (int k = 0; k < 3; k++) begin
            acc_nxt[k] = '0;
          end
          row_nxt   = '0;
          col_nxt   = '0;
          ph_nxt    = 1'b0;
          state_nxt = ST_GATE;
        end
      end

      ST_GATE: begin
        if (mac_last) begin
          state_nxt = ST_STORE;
        end
      end

      // Decide the gate, store the sample and prepare the ring walk.
      ST_STORE: begin
        gate_ok = (acc_r[0] >= ACC_NORM2_LO) && (acc_r[0] <= ACC_NORM2_HI) &&
                  !(gp_r && (acc_r[1] > RATE_NORM2_MAX));
        accepted_nxt = gate_ok;
        if (win_cfg_r == '0) begin
          win32 = 32'd1;
        end else if (32'(win_cfg_r) > 32'(WINDOW_DEPTH)) begin
          win32 = 32'(WINDOW_DEPTH);
        end else begin
          win32 = 32'(win_cfg_r);
        end
        if (gate_ok) begin
          ram_we   = 1'b1;
          wp_eff   = (wp_r == LAST_SLOT) ? '0 : wp_r + PTR_W'(1);
          fill_eff = CNT_W'(((fill32 >= win32) ? (win32 - 32'd1) : fill32) + 32'd1);
        end
        wp_nxt      = wp_eff;
        fill_nxt    = fill_eff;
        newest      = (wp_eff == '0) ? LAST_SLOT : wp_eff - PTR_W'(1);
        rd_addr_nxt = newest;
        left_nxt    = fill_eff;
        first_nxt   = 1'b1;
        for (int k = 0; k < 3; k++) begin
          sum_nxt[k] = '0;
        end
        cnt_nxt   = '0;
        state_nxt = ST_WALK;
      end

      // Walk from the newest sample backwards, one RAM read per cycle.
      ST_WALK: begin
        if (left_r != '0) begin
          ram_re      = 1'b1;
          rd_addr_nxt = (rd_addr_r == '0) ? LAST_SLOT : rd_addr_r - PTR_W'(1);
          left_nxt    = left_r - CNT_W'(1);
          pvld_nxt    = 1'b1;
          pfirst_nxt  = first_r;
          first_nxt   = 1'b0;
        end
        if (pvld_r) begin
          ns_use = pfirst_r ? rd_stamp : nstamp_r;
          if (pfirst_r) begin
            nstamp_nxt = rd_stamp;
          end
          age = $signed({2'b00, ns_use}) - $signed({2'b00, rd_stamp});
          walk_keep = (age_cfg_r == '0) ||
                      !(age > $signed({18'd0, age_cfg_r}));
          if (walk_keep) begin
            for (int k = 0; k < 3; k++) begin
              sum_nxt[k] = sum_r[k] + SUM_W'(rd_acc[k]);
            end
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        if ((left_r == '0) && !pvld_r) begin
          state_nxt = ST_DECIDE;
        end
      end

      // Enough usable samples for an estimate?
      ST_DECIDE: begin
        dec_ok = (cnt_r != '0) && (32'(fill_r) >= 32'(req_cfg_r)) &&
                 (32'(cnt_r) >= 32'(req_cfg_r));
        est_ok_nxt = 1'b0;
        ax_nxt     = '0;
        for (int k = 0; k < 3; k++) begin
          acc_nxt[k] = '0;
        end
        state_nxt = dec_ok ? ST_DLOAD : ST_DONE;
      end

      // Load the rounded dividend for one axis.
      ST_DLOAD: begin
        neg_nxt   = sum_r[ax_r][SUM_W-1];
        smag      = sum_r[ax_r][SUM_W-1] ? SUM_W'(-sum_r[ax_r]) : SUM_W'(sum_r[ax_r]);
        num_nxt   = (NUM_W'(smag) << 8) + NUM_W'(cnt_r >> 1);
        rem_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = ST_DIV;
      end

      // Restoring division, one quotient bit per cycle.
      ST_DIV: begin
        dt      = {rem_r[CNT_W-1:0], num_r[NUM_W-1]};
        div_ge  = dt >= {1'b0, cnt_r};
        rem_nxt = div_ge ? dt - {1'b0, cnt_r} : dt;
        num_nxt = {num_r[NUM_W-2:0], div_ge};
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(NUM_W - 1)) begin
          mq = MEAN_W'(num_nxt);
          m_nxt[ax_r] = neg_r ? -$signed(mq) : $signed(mq);
          if (ax_r == 2'd2) begin
            row_nxt   = '0;
            col_nxt   = '0;
            ph_nxt    = 1'b0;
            state_nxt = ST_ROT;
          end else begin
            ax_nxt    = ax_r + 2'd1;
            state_nxt = ST_DLOAD;
          end
        end
      end

      ST_ROT: begin
        if (mac_last) begin
          state_nxt = ST_GRND;
        end
      end

      // Round the rotated vector to the mean's scale.
      ST_GRND: begin
        for (int k = 0; k < 3; k++) begin
          g_nxt[k]   = GRAV_W'(rnd_sh(acc_r[k], 6'd14));
          acc_nxt[k] = '0;
        end
        row_nxt   = '0;
        col_nxt   = '0;
        ph_nxt    = 1'b0;
        state_nxt = ST_NORM;
      end

      ST_NORM: begin
        if (mac_last) begin
          state_nxt = ST_NCHK;
        end
      end

      // Reject a vanishing gravity vector, else start the square root.
      ST_NCHK: begin
        if (acc_r[0] > GRAV_NORM2_MIN) begin
          sq_v_nxt   = 64'(acc_r[1]);
          sq_res_nxt = '0;
          si_nxt     = '0;
          state_nxt  = ST_SQRT;
        end else begin
          est_ok_nxt = 1'b0;
          state_nxt  = ST_DONE;
        end
      end

      // Integer square root, two radicand bits per cycle.
      ST_SQRT: begin
        sq_bit = 64'd1 << (6'd62 - {si_r, 1'b0});
        sq_try = sq_res_r + sq_bit;
        if (sq_v_r >= sq_try) begin
          sq_v_nxt   = sq_v_r - sq_try;
          sq_res_nxt = (sq_res_r >> 1) + sq_bit;
        end else begin
          sq_res_nxt = sq_res_r >> 1;
        end
        si_nxt = si_r + 5'd1;
        if (si_r == 5'd31) begin
          which_nxt = 1'b0;
          state_nxt = ST_CPRE;
        end
      end

      // Load the CORDIC vector, turning a left-half vector by a quarter turn.
      ST_CPRE: begin
        if (which_r) begin
          x0 = CRD_W'(g_r[2]);
          y0 = CRD_W'(g_r[1]);
        end else begin
          x0 = CRD_W'(sq_res_r);
          y0 = -CRD_W'(g_r[0]);
        end
        ci_nxt = '0;
        if ((x0 == '0) && (y0 == '0)) begin
          cz_nxt    = '0;
          state_nxt = ST_CFIN;
        end else if (x0 < 0) begin
          if (y0 >= 0) begin
            cx_nxt = y0;
            cy_nxt = -x0;
            cz_nxt = HALF_PI_Q24;
          end else begin
            cx_nxt = -y0;
            cy_nxt = x0;
            cz_nxt = -HALF_PI_Q24;
          end
          state_nxt = ST_CORD;
        end else begin
          cx_nxt    = x0;
          cy_nxt    = y0;
          cz_nxt    = '0;
          state_nxt = ST_CORD;
        end
      end

      // One vectoring step per cycle through the shared shifter.
      ST_CORD: begin
        dx = cy_r >>> ci_r;
        dy = cx_r >>> ci_r;
        if (cy_r >= 0) begin
          cx_nxt = cx_r + dx;
          cy_nxt = cy_r - dy;
          cz_nxt = cz_r + ANG_W'(atan_q24(ci_r));
        end else begin
          cx_nxt = cx_r - dx;
          cy_nxt = cy_r + dy;
          cz_nxt = cz_r - ANG_W'(atan_q24(ci_r));
        end
        ci_nxt = ci_r + 5'd1;
        if (ci_r == 5'(STEPS - 1)) begin
          state_nxt = ST_CFIN;
        end
      end

      // Scale the angle and saturate it to the field.
      ST_CFIN: begin
        rz = rnd_sh(64'(cz_r), 6'd10);
        if (!which_r) begin
          if (rz < -64'sd32768) begin
            pitch_nxt = PITCH_W'(-64'sd32768);
          end else if (rz > 64'sd32767) begin
            pitch_nxt = PITCH_W'(64'sd32767);
          end else begin
            pitch_nxt = PITCH_W'(rz);
          end
          which_nxt = 1'b1;
          state_nxt = ST_CPRE;
        end else begin
          if (rz < -64'sd65536) begin
            roll_nxt = ROLL_W'(-64'sd65536);
          end else if (rz > 64'sd65535) begin
            roll_nxt = ROLL_W'(64'sd65535);
          end else begin
            roll_nxt = ROLL_W'(rz);
          end
          est_ok_nxt = 1'b1;
          state_nxt  = ST_DONE;
        end
      end

      // Hand the result to the output register once it is free.
      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          o_acc_nxt     = accepted_r;
          o_est_nxt     = est_ok_r;
          o_pitch_nxt   = est_ok_r ? pitch_r : '0;
          o_roll_nxt    = est_ok_r ? roll_r : '0;
          o_used_nxt    = (32'(cnt_r) > 32'd127) ? 7'd127 : USED_W'(cnt_r);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register and control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      pvld_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      pvld_r      <= pvld_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cfg_r <= WIN_RST;
      req_cfg_r <= REQ_RST;
      age_cfg_r <= '0;
      rot_r[0]  <= ROW_X_RST;
      rot_r[1]  <= ROW_Y_RST;
      rot_r[2]  <= ROW_Z_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_WINDOW:   win_cfg_r <= cfg_wdata[WIN_W-1:0];
        CFG_REQUIRED: req_cfg_r <= cfg_wdata[WIN_W-1:0];
        CFG_MAX_AGE:  age_cfg_r <= cfg_wdata[AGE_W-1:0];
        CFG_ROT_X:    rot_r[0]  <= cfg_wdata[ROW_W-1:0];
        CFG_ROT_Y:    rot_r[1]  <= cfg_wdata[ROW_W-1:0];
        CFG_ROT_Z:    rot_r[2]  <= cfg_wdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    w_r        <= w_nxt;
    gp_r       <= gp_nxt;
    stamp_r    <= stamp_nxt;
    acc_r      <= acc_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    ph_r       <= ph_nxt;
    accepted_r <= accepted_nxt;
    rd_addr_r  <= rd_addr_nxt;
    left_r     <= left_nxt;
    first_r    <= first_nxt;
    pfirst_r   <= pfirst_nxt;
    nstamp_r   <= nstamp_nxt;
    sum_r      <= sum_nxt;
    cnt_r      <= cnt_nxt;
    ax_r       <= ax_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    dcnt_r     <= dcnt_nxt;
    neg_r      <= neg_nxt;
    m_r        <= m_nxt;
    g_r        <= g_nxt;
    sq_v_r     <= sq_v_nxt;
    sq_res_r   <= sq_res_nxt;
    si_r       <= si_nxt;
    which_r    <= which_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    cz_r       <= cz_nxt;
    ci_r       <= ci_nxt;
    pitch_r    <= pitch_nxt;
    roll_r     <= roll_nxt;
    est_ok_r   <= est_ok_nxt;
    o_acc_r    <= o_acc_nxt;
    o_est_r    <= o_est_nxt;
    o_pitch_r  <= o_pitch_nxt;
    o_roll_r   <= o_roll_nxt;
    o_used_r   <= o_used_nxt;
  end

  // Result channel.
  assign out_chan.valid           = out_valid_r;
  assign out_chan.sample_accepted = o_acc_r;
  assign out_chan.estimate_valid  = o_est_r;
  assign out_chan.pitch           = o_pitch_r;
  assign out_chan.roll            = o_roll_r;
  assign out_chan.samples_used    = o_used_r;

endmodule

// ===== hw/rtl/gte_checker.sv =====
// ----------------------------------------------------------------------------
// gte_checker: port-level checks for the tilt estimator
// Watches the channel ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module gte_checker
  import gte_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_est_valid,
  input logic signed [PITCH_W-1:0] out_pitch,
  input logic signed [ROLL_W-1:0]  out_roll,
  input logic [USED_W-1:0]         out_used
);

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pitch) &&
    $stable(out_roll) && $stable(out_used))
    else $error("result item changed while stalled");

  // An invalid estimate reports zero angles.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_est_valid |-> out_pitch == 0 && out_roll == 0)
    else $error("invalid estimate carries nonzero angles");

  // A valid estimate was built from at least one sample.
  a_valid_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_est_valid |-> out_used != 0)
    else $error("valid estimate with no samples used");

  // One item at a time: no new item right after one is taken.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  // Roll stays within the quarter turn plus the full CORDIC angle sum.
  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_est_valid |-> out_roll <= 54298 && out_roll >= -54298)
    else $error("roll outside the CORDIC reach");

endmodule

bind gated_accel_tilt_estimator gte_checker u_gte_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_est_valid (out_chan.estimate_valid),
  .out_pitch     (out_chan.pitch),
  .out_roll      (out_chan.roll),
  .out_used      (out_chan.samples_used)
);

// ===== sim/tb_gated_accel_tilt_estimator.sv =====
// ----------------------------------------------------------------------------
// tb_gated_accel_tilt_estimator: self-checking bench for the tilt estimator
// Streams IMU samples through the valid/ready channels under several register
// settings and compares every returned item, field by field, against a
// cycle-free software estimate of the gated ring average and its CORDIC angles.
// ----------------------------------------------------------------------------
module tb_gated_accel_tilt_estimator;
  timeunit 1ns;
  timeprecision 1ps;
  import gte_pkg::*;

  localparam int       RING_DEPTH  = 64;
  localparam int       ANGLE_STEPS = 16;
  localparam longint   GATE_LO     = 63959047;
  localparam longint   GATE_HI     = 146251290;
  localparam longint   SPIN_MAX    = 2044252;
  localparam longint   GRAV_MIN    = 68719;
  localparam longint   QUARTER_TURN = 26353589;
  localparam longint   CYCLE_LIMIT = 4000000;
  localparam longint   ATAN_TAB[ANGLE_STEPS] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512};

  typedef struct {
    logic signed [ACC_W-1:0]  acc_x, acc_y, acc_z;
    logic                     gyro;
    logic signed [RATE_W-1:0] rate_x, rate_y, rate_z;
    logic [STAMP_W-1:0]       stamp;
  } imu_sample_t;

  typedef struct {
    logic               accepted;
    logic               valid;
    logic [PITCH_W-1:0] pitch;
    logic [ROLL_W-1:0]  roll;
    logic [USED_W-1:0]  used;
  } tilt_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  gte_in_if  in_if();
  gte_out_if out_if();

  gated_accel_tilt_estimator i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // Clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: the sample ring and a copy of the registers.
  longint       ring_acc[RING_DEPTH][3];
  longint       ring_stamp[RING_DEPTH];
  int           ring_wr;
  int           ring_fill;
  int           win_reg;
  int           req_reg;
  longint       age_reg;
  logic [47:0]  rot_reg[3];

  imu_sample_t  sample_q[$];
  tilt_t        tilt_q[$];
  int           err_cnt = 0;
  longint       cycles = 0;
  bit           took = 0;
  bit           calm = 0;
  bit           long_hold_req = 0;
  int           send_gap = 0;
  int           recv_gap = 0;
  logic [47:0]  stamp_now = '0;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned probe = 64'h1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v -= res + probe;
        res = (res >> 1) + probe;
      end else begin
        res >>= 1;
      end
      probe >>= 2;
    end
    return res;
  endfunction

  function automatic longint round_shift(longint v, int k);
    longint m;
    m = ((v < 0 ? -v : v) + (64'sd1 <<< (k - 1))) >>> k;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint div_round(longint num, longint den);
    longint q;
    q = ((num < 0 ? -num : num) + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // atan2(y, x) by CORDIC vectoring, in units of 2^-24 rad.
  function automatic longint cordic_angle(longint x, longint y);
    longint z = 0;
    longint t, dx, dy;
    if (x == 0 && y == 0) return 0;
    // Left half plane: turn by a quarter first.
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = QUARTER_TURN;
      end else begin
        x = -y; y = t; z = -QUARTER_TURN;
      end
    end
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  // Gate the sample, update the ring and work out the tilt result.
  function automatic tilt_t predict_tilt(imu_sample_t s);
    longint a[3], w[3], sum[3], m[3], g[3];
    longint an2, wn2, acc, n2, r, nst, age;
    int win, newest, idx, cnt;
    bit ok;
    tilt_t res;
    a[0] = s.acc_x;  a[1] = s.acc_y;  a[2] = s.acc_z;
    w[0] = s.rate_x; w[1] = s.rate_y; w[2] = s.rate_z;
    an2 = 0; wn2 = 0; cnt = 0;
    for (int k = 0; k < 3; k++) begin
      an2 += a[k] * a[k];
      wn2 += w[k] * w[k];
      sum[k] = 0;
    end
    ok = an2 >= GATE_LO && an2 <= GATE_HI;
    if (s.gyro && wn2 > SPIN_MAX) ok = 0;

    // Store an accepted sample, trimming the ring to the current window.
    if (ok) begin
      win = win_reg < 1 ? 1 : (win_reg > RING_DEPTH ? RING_DEPTH : win_reg);
      if (ring_fill >= win) ring_fill = win - 1;
      for (int k = 0; k < 3; k++) ring_acc[ring_wr][k] = a[k];
      ring_stamp[ring_wr] = s.stamp;
      ring_wr = (ring_wr + 1) % RING_DEPTH;
      ring_fill++;
    end

    // Sum the samples that pass the age filter.
    if (ring_fill > 0) begin
      newest = (ring_wr + RING_DEPTH - 1) % RING_DEPTH;
      nst = ring_stamp[newest];
      for (int i = 0; i < ring_fill; i++) begin
        idx = (newest + RING_DEPTH - i) % RING_DEPTH;
        age = nst - ring_stamp[idx];
        if (age_reg != 0 && age > age_reg) continue;
        for (int k = 0; k < 3; k++) sum[k] += ring_acc[idx][k];
        cnt++;
      end
    end

    res.accepted = ok;
    res.valid    = 1'b0;
    res.pitch    = '0;
    res.roll     = '0;
    res.used     = cnt > 127 ? 7'd127 : USED_W'(cnt);

    if (cnt > 0 && ring_fill >= req_reg && cnt >= req_reg) begin
      n2 = 0;
      for (int k = 0; k < 3; k++) m[k] = div_round(sum[k] * 256, cnt);
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++)
          acc += longint'($signed(rot_reg[j][16*k +: 16])) * m[k];
        g[j] = round_shift(acc, 14);
        n2 += g[j] * g[j];
      end
      if (n2 > GRAV_MIN) begin
        r = longint'(isqrt(g[1] * g[1] + g[2] * g[2]));
        res.valid = 1'b1;
        res.pitch = PITCH_W'(clamp(round_shift(cordic_angle(r, -g[0]), 10), -32768, 32767));
        res.roll  = ROLL_W'(clamp(round_shift(cordic_angle(g[2], g[1]), 10), -65536, 65535));
      end
    end
    return res;
  endfunction

  // Random sample: mostly quasi-static with random attitude, plus noise.
  function automatic imu_sample_t random_sample();
    imu_sample_t s;
    longint n, ax, ay, az, rem, t;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      n   = $urandom_range(7900, 12200);
      if (pick >= 72) n = pick[0] ? $urandom_range(5000, 7990) : $urandom_range(12100, 16000);
      ax  = longint'($urandom_range(0, 2 * n)) - n;
      rem = n * n - ax * ax;
      t   = isqrt(rem);
      ay  = longint'($urandom_range(0, 2 * t)) - t;
      az  = isqrt(rem - ay * ay);
      if ($urandom_range(0, 1)) az = -az;
      s.acc_x = ax; s.acc_y = ay; s.acc_z = az;
    end else begin
      s.acc_x = $urandom; s.acc_y = $urandom; s.acc_z = $urandom;
    end
    s.gyro = $urandom_range(0, 1);
    if ($urandom_range(0, 4) != 0) begin
      s.rate_x = longint'($urandom_range(0, 1600)) - 800;
      s.rate_y = longint'($urandom_range(0, 1600)) - 800;
      s.rate_z = longint'($urandom_range(0, 1600)) - 800;
    end else begin
      s.rate_x = $urandom; s.rate_y = $urandom; s.rate_z = $urandom;
    end
    pick = $urandom_range(0, 99);
    if (pick < 90)      stamp_now = stamp_now + $urandom_range(0, 3000);
    else if (pick < 95) stamp_now = stamp_now - $urandom_range(0, 3000);
    else                stamp_now = {$urandom, $urandom};
    s.stamp = stamp_now;
    return s;
  endfunction

  function automatic imu_sample_t mk(longint ax, longint ay, longint az, bit gyro,
                                     longint wx, longint wy, longint wz,
                                     logic [47:0] st);
    imu_sample_t s;
    s.acc_x = ax; s.acc_y = ay; s.acc_z = az; s.gyro = gyro;
    s.rate_x = wx; s.rate_y = wy; s.rate_z = wz; s.stamp = st;
    return s;
  endfunction

  // Register write, mirrored into the predictor.
  task automatic cfg_write(cfg_idx_t idx, logic [47:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_WINDOW:   win_reg = val[6:0];
      CFG_REQUIRED: req_reg = val[6:0];
      CFG_MAX_AGE:  age_reg = val[31:0];
      CFG_ROT_X:    rot_reg[0] = val;
      CFG_ROT_Y:    rot_reg[1] = val;
      CFG_ROT_Z:    rot_reg[2] = val;
      default: ;
    endcase
  endtask

  function automatic logic [47:0] random_row(int sel, int pos);
    logic [15:0] e[3];
    case (sel)
      0: begin
        e = '{16'h0, 16'h0, 16'h0};
        e[pos] = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
      end
      1: for (int k = 0; k < 3; k++) e[k] = $urandom;
      2: for (int k = 0; k < 3; k++) e[k] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: e = '{16'h0, 16'h0, 16'h0};
    endcase
    return {e[2], e[1], e[0]};
  endfunction

  task automatic random_config();
    int sel, perm;
    case ($urandom_range(0, 5))
      0: cfg_write(CFG_WINDOW, 48'd1);
      1: cfg_write(CFG_WINDOW, 48'd0);
      2: cfg_write(CFG_WINDOW, 48'd127);
      default: cfg_write(CFG_WINDOW, 48'($urandom_range(2, 64)));
    endcase
    case ($urandom_range(0, 5))
      0: cfg_write(CFG_REQUIRED, 48'd0);
      1: cfg_write(CFG_REQUIRED, 48'd64);
      2: cfg_write(CFG_REQUIRED, 48'd127);
      default: cfg_write(CFG_REQUIRED, 48'($urandom_range(1, 12)));
    endcase
    case ($urandom_range(0, 3))
      0, 1: cfg_write(CFG_MAX_AGE, 48'd0);
      2: cfg_write(CFG_MAX_AGE, 48'($urandom_range(1, 20000)));
      default: cfg_write(CFG_MAX_AGE, 48'hFFFF_FFFF);
    endcase
    sel  = $urandom_range(0, 9);
    sel  = sel < 5 ? 0 : (sel < 8 ? 1 : (sel < 9 ? 2 : 3));
    perm = $urandom_range(0, 2);
    cfg_write(CFG_ROT_X, random_row(sel, perm));
    cfg_write(CFG_ROT_Y, random_row(sel, (perm + 1) % 3));
    cfg_write(CFG_ROT_Z, random_row(sel, (perm + 2) % 3));
  endtask

  // Wait until every queued item is sent and every result has come back.
  task automatic drain();
    while (sample_q.size() != 0 || tilt_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Sender: note each accepted item and predict its result.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      tilt_q.push_back(predict_tilt(sample_q.pop_front()));
      took = 1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !took) begin
      // Hold the offered item until it is taken.
    end else if (send_gap > 0) begin
      in_if.valid <= 1'b0;
      send_gap--;
    end else if (sample_q.size() != 0 && !calm && $urandom_range(0, 9) == 0) begin
      in_if.valid <= 1'b0;
      send_gap = $urandom_range(0, 2);
    end else if (sample_q.size() != 0) begin
      in_if.valid        <= 1'b1;
      in_if.acc_x        <= sample_q[0].acc_x;
      in_if.acc_y        <= sample_q[0].acc_y;
      in_if.acc_z        <= sample_q[0].acc_z;
      in_if.gyro_present <= sample_q[0].gyro;
      in_if.rate_x       <= sample_q[0].rate_x;
      in_if.rate_y       <= sample_q[0].rate_y;
      in_if.rate_z       <= sample_q[0].rate_z;
      in_if.stamp_us     <= sample_q[0].stamp;
    end else begin
      in_if.valid <= 1'b0;
    end
    took = 0;
  end

  // Receiver back-pressure, including one long hold-off on request.
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 0;
      recv_gap = 3000;
      out_if.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      out_if.ready <= 1'b0;
      recv_gap--;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_if.ready <= 1'b0;
      recv_gap = $urandom_range(0, 2);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin : check_results
    tilt_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (tilt_q.size() == 0) begin
        $error("result item with no expected estimate pending");
        err_cnt++;
      end else begin
        e = tilt_q.pop_front();
        if (out_if.sample_accepted !== e.accepted) begin
          $error("sample_accepted: expected %0d, got %0d", e.accepted, out_if.sample_accepted);
          err_cnt++;
        end
        if (out_if.estimate_valid !== e.valid) begin
          $error("estimate_valid: expected %0d, got %0d", e.valid, out_if.estimate_valid);
          err_cnt++;
        end
        if (out_if.pitch !== e.pitch) begin
          $error("pitch: expected %0d, got %0d", $signed(e.pitch), out_if.pitch);
          err_cnt++;
        end
        if (out_if.roll !== e.roll) begin
          $error("roll: expected %0d, got %0d", $signed(e.roll), out_if.roll);
          err_cnt++;
        end
        if (out_if.samples_used !== e.used) begin
          $error("samples_used: expected %0d, got %0d", e.used, out_if.samples_used);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0;
    in_if.valid = 1'b0; in_if.acc_x = '0; in_if.acc_y = '0; in_if.acc_z = '0;
    in_if.gyro_present = 1'b0; in_if.rate_x = '0; in_if.rate_y = '0; in_if.rate_z = '0;
    in_if.stamp_us = '0;
    out_if.ready = 1'b0;
    ring_wr = 0; ring_fill = 0;
    win_reg = 64; req_reg = 10; age_reg = 0;
    rot_reg[0] = 48'h0000_0000_4000;
    rot_reg[1] = 48'h0000_4000_0000;
    rot_reg[2] = 48'h4000_0000_0000;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed samples under the reset setup, first at its defaults.
    sample_q.push_back(mk(0, 0, 10045, 0, 0, 0, 0, 48'd100));
    drain();
    cfg_write(CFG_REQUIRED, 48'd1);
    sample_q.push_back(mk(262143, 262143, 262143, 0, 0, 0, 0, 48'd200));
    sample_q.push_back(mk(-262144, -262144, -262144, 0, 0, 0, 0, 48'd300));
    sample_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 48'd400));
    sample_q.push_back(mk(0, 0, -10045, 0, 0, 0, 0, 48'd500));
    sample_q.push_back(mk(10045, 0, 0, 1, 10, -10, 5, 48'd600));
    sample_q.push_back(mk(-10045, 0, 0, 0, 0, 0, 0, 48'd700));
    sample_q.push_back(mk(0, 10045, 0, 0, 0, 0, 0, 48'd800));
    sample_q.push_back(mk(0, -10045, 0, 0, 0, 0, 0, 48'd900));
    sample_q.push_back(mk(0, 0, 10045, 1, 1048575, 1048575, 1048575, 48'd1000));
    sample_q.push_back(mk(0, 0, 10045, 0, -1048576, -1048576, -1048576, 48'd1100));
    sample_q.push_back(mk(0, 0, 10045, 1, 800, 800, 800, 48'd1200));
    sample_q.push_back(mk(0, 0, 10045, 1, 826, 826, 826, 48'd1300));
    sample_q.push_back(mk(7998, 0, 0, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF));
    sample_q.push_back(mk(7997, 0, 0, 0, 0, 0, 0, 48'd0));
    sample_q.push_back(mk(12093, 0, 0, 0, 0, 0, 0, 48'd0));
    sample_q.push_back(mk(0, 12094, 0, 0, 0, 0, 0, 48'd5));
    sample_q.push_back(mk(0, -5, -10045, 0, 0, 0, 0, 48'd10));
    sample_q.push_back(mk(0, 5, -10045, 0, 0, 0, 0, 48'd20));
    sample_q.push_back(mk(-7000, -5000, -5000, 0, 0, 0, 0, 48'd30));
    drain();

    // A zero mounting matrix leaves no gravity: the norm check fails.
    cfg_write(CFG_ROT_X, 48'd0);
    cfg_write(CFG_ROT_Y, 48'd0);
    cfg_write(CFG_ROT_Z, 48'd0);
    sample_q.push_back(mk(0, 0, 10045, 0, 0, 0, 0, 48'd40));
    sample_q.push_back(mk(3000, 4000, 9000, 0, 0, 0, 0, 48'd50));
    drain();

    // Extreme settings: full window with full requirement, then a one-entry ring.
    cfg_write(CFG_WINDOW, 48'd64);
    cfg_write(CFG_REQUIRED, 48'd64);
    cfg_write(CFG_MAX_AGE, 48'hFFFF_FFFF);
    cfg_write(CFG_ROT_X, 48'h0000_0000_4000);
    cfg_write(CFG_ROT_Y, 48'h0000_4000_0000);
    cfg_write(CFG_ROT_Z, 48'h4000_0000_0000);
    for (int i = 0; i < 110; i++) sample_q.push_back(random_sample());
    long_hold_req = 1;
    drain();
    cfg_write(CFG_WINDOW, 48'd1);
    cfg_write(CFG_REQUIRED, 48'd1);
    cfg_write(CFG_MAX_AGE, 48'd1);
    for (int i = 0; i < 100; i++) sample_q.push_back(random_sample());
    drain();

    // Random settings.
    for (int p = 0; p < 10; p++) begin
      random_config();
      for (int i = 0; i < 120; i++) sample_q.push_back(random_sample());
      drain();
    end

    // Last stretch without idling on either side.
    calm = 1;
    random_config();
    for (int i = 0; i < 170; i++) sample_q.push_back(random_sample());
    drain();
    repeat (300) @(posedge clk);

    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
